[rtl/core/signed_radix_digit_formatter_defines.svh]
// assertion macros used by the formatter checker
`ifndef SIGNED_RADIX_DIGIT_FORMATTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SRDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SRDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/srdf_pkg.sv]
// shared types and constants of the signed radix digit formatter
package srdf_pkg;

  // fixed field and register widths
  localparam int VALUE_W      = 32;
  localparam int CHAR_W       = 7;
  localparam int SYM_W        = 8;
  localparam int LEN_W        = 6;
  localparam int WORD_W       = 64;
  localparam int NUM_WORDS    = 4;
  localparam int SYMBOL_SLOTS = 32;
  localparam int SYM_IDX_W    = 5;
  localparam int SYMS_PER_WORD = WORD_W / SYM_W;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LEN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORD0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORD1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WORD2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WORD3 = 3'd4;

  // character constants
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
  localparam logic [SYM_W-1:0] CH_LOW   = 8'd33;
  localparam logic [SYM_W-1:0] CH_HIGH  = 8'd126;

  // divider: quotient bits resolved per cycle
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  // output beat selection
  localparam int EMIT_W = 3;
  localparam logic [EMIT_W-1:0] EMIT_NONE  = 3'd0;
  localparam logic [EMIT_W-1:0] EMIT_BAD   = 3'd1;
  localparam logic [EMIT_W-1:0] EMIT_SIGN  = 3'd2;
  localparam logic [EMIT_W-1:0] EMIT_ZERO  = 3'd3;
  localparam logic [EMIT_W-1:0] EMIT_DIGIT = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic [SYM_IDX_W-1:0] chk_idx;
    logic                 div_step;
    logic                 div_first;
    logic                 div_last;
    logic                 load_ptr;
    logic                 dec_ptr;
    logic [EMIT_W-1:0]    emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_bad;
    logic sym_bad;
    logic chk_last;
    logic neg;
    logic mag_zero;
    logic count_full;
    logic out_last;
  } stat_t;

endpackage

[rtl/core/srdf_datapath.sv]
// datapath: alphabet registers, validation, radix divider, digit store, output mux
module srdf_datapath import srdf_pkg::*; #(
  parameter int MAX_RADIX   = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [REG_IDX_W-1:0]        wr_index,
  input  logic [WORD_W-1:0]           wr_data,
  input  logic signed [VALUE_W-1:0]   value,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  output logic [CHAR_W-1:0]           character,
  output logic                        bad_alphabet,
  output logic                        last
);

  localparam int RADIX_LIMIT = (MAX_RADIX < SYMBOL_SLOTS) ? MAX_RADIX : SYMBOL_SLOTS;
  localparam int DIGIT_W     = $clog2(RADIX_LIMIT);
  localparam int IDX_W       = $clog2(DIGIT_SLOTS);
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(RADIX_LIMIT);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGIT_SLOTS);

  logic [LEN_W-1:0]   alpha_len;
  logic [WORD_W-1:0]  alpha_word [NUM_WORDS];
  logic [SYM_W-1:0]   sym [SYMBOL_SLOTS];

  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [LEN_W-1:0]   rem;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;
  logic [DIGIT_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_pos;
  logic [DIGIT_W-1:0] digit_store [DIGIT_SLOTS];

  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] abs_val;
  logic [VALUE_W-1:0] q_next;
  logic [LEN_W-1:0]   r_next;
  logic [SYM_W-1:0]   sym_a;
  logic               range_bad;
  logic               dup;
  logic [SYM_IDX_W-1:0] dig_idx;

  // configuration registers and per-item state
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_len <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        alpha_word[w] <= '0;
      end
      neg   <= 1'b0;
      mag   <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LEN:   alpha_len     <= wr_data[LEN_W-1:0];
          REG_WORD0: alpha_word[0] <= wr_data;
          REG_WORD1: alpha_word[1] <= wr_data;
          REG_WORD2: alpha_word[2] <= wr_data;
          REG_WORD3: alpha_word[3] <= wr_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        neg   <= raw[VALUE_W-1];
        mag   <= abs_val;
        count <= '0;
      end else if (cmd.div_step) begin
        mag <= q_next;
      end
      if (cmd.div_last) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // unpack symbols from the alphabet words
  for (genvar i = 0; i < SYMBOL_SLOTS; i++) begin : g_sym
    assign sym[i] = alpha_word[i / SYMS_PER_WORD][(i % SYMS_PER_WORD) * SYM_W +: SYM_W];
  end

  // magnitude of the input, taken as unsigned so the most negative value works
  assign raw     = value;
  assign abs_val = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

  // validation of one symbol per cycle against all later ones
  assign sym_a     = sym[cmd.chk_idx];
  assign range_bad = (sym_a == CH_PLUS) || (sym_a == CH_MINUS) ||
                     (sym_a < CH_LOW) || (sym_a > CH_HIGH);

  always_comb begin
    dup = 1'b0;
    for (int b = 0; b < SYMBOL_SLOTS; b++) begin
      if ((SYM_IDX_W'(b) > cmd.chk_idx) && (LEN_W'(b) < alpha_len) && (sym[b] == sym_a)) begin
        dup = 1'b1;
      end
    end
  end

  // long division by the radix, a byte of quotient bits per cycle
  always_comb begin
    logic [LEN_W:0]     trial;
    logic [LEN_W-1:0]   r;
    logic [VALUE_W-1:0] q;
    q     = mag;
    r     = cmd.div_first ? '0 : rem;
    trial = '0;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      trial = {r, q[VALUE_W-1]};
      q     = {q[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, alpha_len}) begin
        trial = trial - {1'b0, alpha_len};
        q[0]  = 1'b1;
      end
      r = trial[LEN_W-1:0];
    end
    q_next = q;
    r_next = r;
  end

  // remainder, read pointer and digit store
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      rem <= r_next;
    end
    if (cmd.div_last) begin
      digit_store[count[IDX_W-1:0]] <= r_next[DIGIT_W-1:0];
    end
    if (cmd.load_ptr) begin
      ptr <= IDX_W'(count - CNT_W'(1));
    end else if (cmd.dec_ptr && (ptr != '0)) begin
      ptr <= ptr - IDX_W'(1);
    end
    rd_data <= digit_store[ptr];
    rd_pos  <= ptr;
  end

  // status back to the controller
  assign stat.len_bad    = (alpha_len < LEN_W'(2)) || (alpha_len > LEN_MAX);
  assign stat.sym_bad    = range_bad || dup;
  assign stat.chk_last   = ({1'b0, cmd.chk_idx} == (alpha_len - LEN_W'(1)));
  assign stat.neg        = neg;
  assign stat.mag_zero   = (mag == '0);
  assign stat.count_full = (count == CNT_FULL);
  assign stat.out_last   = (rd_pos == '0);

  // result beat fields
  assign dig_idx = SYM_IDX_W'(rd_data);

  always_comb begin
    character    = '0;
    bad_alphabet = 1'b0;
    last         = 1'b0;
    case (cmd.emit)
      EMIT_BAD: begin
        bad_alphabet = 1'b1;
        last         = 1'b1;
      end
      EMIT_SIGN: begin
        character = CH_MINUS[CHAR_W-1:0];
      end
      EMIT_ZERO: begin
        character = sym[0][CHAR_W-1:0];
        last      = 1'b1;
      end
      EMIT_DIGIT: begin
        character = sym[dig_idx][CHAR_W-1:0];
        last      = (rd_pos == '0);
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/srdf_ctrl.sv]
// controller state machine: validate, divide, then stream characters
module srdf_ctrl import srdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  strobe
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_BAD   = 4'd2;
  localparam logic [3:0] S_SIGN  = 4'd3;
  localparam logic [3:0] S_ZERO  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_PRIME = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [3:0]           state, state_next;
  logic [SYM_IDX_W-1:0] chk_idx, chk_idx_next;
  logic [STEP_W-1:0]    step, step_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      chk_idx <= '0;
      step    <= '0;
    end else begin
      state   <= state_next;
      chk_idx <= chk_idx_next;
      step    <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    chk_idx_next = chk_idx;
    step_next    = step;
    cmd          = '0;
    cmd.chk_idx  = chk_idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          chk_idx_next = '0;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.len_bad || stat.sym_bad) begin
          state_next = S_BAD;
        end else if (stat.chk_last) begin
          state_next = S_SIGN;
        end else begin
          chk_idx_next = chk_idx + SYM_IDX_W'(1);
        end
      end
      S_BAD: begin
        cmd.emit   = EMIT_BAD;
        state_next = S_IDLE;
      end
      S_SIGN: begin
        if (stat.neg) begin
          cmd.emit = EMIT_SIGN;
        end
        step_next  = '0;
        state_next = stat.mag_zero ? S_ZERO : S_DIV;
      end
      S_ZERO: begin
        cmd.emit   = EMIT_ZERO;
        state_next = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
        cmd.div_last  = (step == STEP_LAST);
        step_next     = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        step_next = '0;
        if (stat.mag_zero || stat.count_full) begin
          cmd.load_ptr = 1'b1;
          state_next   = S_PRIME;
        end else begin
          state_next = S_DIV;
        end
      end
      S_PRIME: begin
        cmd.dec_ptr = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit    = EMIT_DIGIT;
        cmd.dec_ptr = 1'b1;
        if (stat.out_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign strobe = (cmd.emit != EMIT_NONE);

endmodule

[rtl/core/signed_radix_digit_formatter.sv]
// top level: formats a signed 32-bit value as text in a configured radix
//
// Pulse start while busy is low to hand over value; busy stays high until the
// last character has gone out. Characters come one per strobe beat, sign first,
// and each strobe lasts one cycle: the receiver must take every beat, there is no
// stall. Validation checks the alphabet symbol by symbol. Per digit, the divider
// then steps through the magnitude eight quotient bits at a time, storing the
// remainder as the digit, and a bookkeeping state decides whether another digit
// follows. After a priming state the characters come from the digit store's
// registered read port. A bad alphabet ends after validation with a single
// flagged beat. Write the alphabet registers only while busy is low.
module signed_radix_digit_formatter import srdf_pkg::*; #(
  parameter int MAX_RADIX   = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      strobe,
  output logic [CHAR_W-1:0]         character,
  output logic                      bad_alphabet,
  output logic                      last,
  input  logic                      wr_en,
  input  logic [REG_IDX_W-1:0]      wr_index,
  input  logic [WORD_W-1:0]         wr_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  srdf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // datapath
  srdf_datapath #(
    .MAX_RADIX   (MAX_RADIX),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .value        (value),
    .cmd          (cmd),
    .stat         (stat),
    .character    (character),
    .bad_alphabet (bad_alphabet),
    .last         (last)
  );

endmodule

[rtl/core/srdf_checker.sv]
// port-level checker for the formatter, bound to the top level
`include "signed_radix_digit_formatter_defines.svh"

module srdf_checker import srdf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] character,
  input logic              bad_alphabet,
  input logic              last
);

  // a flagged beat is the whole answer and carries no character
  `SRDF_ASSERT_NOW(a_bad_single, strobe && bad_alphabet, last && (character == '0), "bad alphabet beat not final or not empty")

  // text beats carry printable symbols only
  `SRDF_ASSERT_NOW(a_printable, strobe && !bad_alphabet, ({1'b0, character} >= CH_LOW) && ({1'b0, character} <= CH_HIGH), "character outside printable range")

  // after the final beat the block is free again
  `SRDF_ASSERT_NEXT(a_idle_after_last, strobe && last, !busy && !strobe, "block still busy after final beat")

  // beats only come while an item is in flight
  `SRDF_ASSERT_NOW(a_beat_in_flight, strobe, busy, "beat while idle")

  // an accepted value makes the block busy with no beat yet
  `SRDF_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !strobe, "accept did not raise busy")

endmodule

bind signed_radix_digit_formatter srdf_checker u_srdf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .character    (character),
  .bad_alphabet (bad_alphabet),
  .last         (last)
);

[verif/tb_top.sv]
// testbench for the signed radix digit formatter: directed corners, then random values
module tb_top import srdf_pkg::*; ();

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  // bound for the slowest item: at most 32 symbols checked, 32 digits divided, 33 beats out
  localparam int SETTLE_CYCLES  = 300;
  localparam int PHASE_VALUES   = 56;
  localparam int RANDOM_PHASES  = 8;
  localparam int FAULT_ROUNDS   = 4;
  localparam int FAULT_VALUES   = 4;

  // ways to spoil an otherwise good alphabet
  typedef enum int {
    BREAK_SHORT,
    BREAK_LONG,
    BREAK_SIGN,
    BREAK_RANGE,
    BREAK_REPEAT
  } alphabet_fault_t;

  // one output beat as the block should present it
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              bad_alphabet;
    logic              last;
  } char_beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      strobe;
  logic [CHAR_W-1:0]         character;
  logic                      bad_alphabet;
  logic                      last;
  logic                      wr_en = 1'b0;
  logic [REG_IDX_W-1:0]      wr_index = '0;
  logic [WORD_W-1:0]         wr_data = '0;

  // local copy of the alphabet registers
  logic [LEN_W-1:0]  alpha_len;
  logic [WORD_W-1:0] alpha_words [NUM_WORDS];
  logic [SYM_W-1:0]  sym_buf [SYMBOL_SLOTS];

  char_beat_t expected_chars [$];
  int         errors = 0;
  int         values_sent = 0;
  int         beats_checked = 0;
  int         alphabets_loaded = 0;
  int         idle_pct = 0;

  signed_radix_digit_formatter uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .strobe       (strobe),
    .character    (character),
    .bad_alphabet (bad_alphabet),
    .last         (last),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Regression FAIL");
    $finish;
  end

  // symbol held at a given alphabet position
  function automatic logic [SYM_W-1:0] symbol_of(input int idx);
    if (idx >= SYMBOL_SLOTS) return '0;
    return alpha_words[idx / SYMS_PER_WORD][(idx % SYMS_PER_WORD) * SYM_W +: SYM_W];
  endfunction

  // length in range, printable symbols, no sign symbols, no repeats
  function automatic bit alphabet_valid();
    int n;
    logic [SYM_W-1:0] s;
    n = int'(alpha_len);
    // the radix limit and the symbol store are both 32 deep
    if (n < 2 || n > SYMBOL_SLOTS) return 1'b0;
    for (int a = 0; a < n; a++) begin
      s = symbol_of(a);
      if (s == CH_PLUS || s == CH_MINUS || s < CH_LOW || s > CH_HIGH) return 1'b0;
      for (int b = a + 1; b < n; b++)
        if (symbol_of(b) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the beats that one value should produce
  task automatic predict_text(input logic [VALUE_W-1:0] raw);
    char_beat_t       beat;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    int               digit_vals [$];
    if (!alphabet_valid()) begin
      beat = '{character: '0, bad_alphabet: 1'b1, last: 1'b1};
      expected_chars.push_back(beat);
      return;
    end
    radix = VALUE_W'(alpha_len);
    // unsigned magnitude, so the most negative value needs no special case
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    if (raw[VALUE_W-1]) begin
      beat = '{character: CH_MINUS[CHAR_W-1:0], bad_alphabet: 1'b0, last: 1'b0};
      expected_chars.push_back(beat);
    end
    if (mag == '0) begin
      beat = '{character: CHAR_W'(symbol_of(0)), bad_alphabet: 1'b0, last: 1'b1};
      expected_chars.push_back(beat);
      return;
    end
    while (mag != '0) begin
      digit_vals.push_back(int'(mag % radix));
      mag = mag / radix;
    end
    for (int i = digit_vals.size() - 1; i >= 0; i--) begin
      beat = '{character: CHAR_W'(symbol_of(digit_vals[i])), bad_alphabet: 1'b0,
               last: i == 0};
      expected_chars.push_back(beat);
    end
  endtask

  // compare every strobe beat with the oldest expected one
  always @(posedge clk) begin : check_beats
    char_beat_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: character %0d bad_alphabet %0b last %0b",
               character, bad_alphabet, last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        beats_checked++;
        if (character !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, character);
          errors++;
        end
        if (bad_alphabet !== want.bad_alphabet) begin
          $error("bad_alphabet: expected %0b, got %0b", want.bad_alphabet, bad_alphabet);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  // hand over one value; start stays high when the next value follows at once
  task automatic send_value(input logic [VALUE_W-1:0] v);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_text(v);
    values_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end
  endtask

  // stop sending and let every expected beat arrive
  task automatic wait_quiet(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0 || busy) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // one register write; the caller lowers wr_en after its last write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LEN:                                alpha_len = data[LEN_W-1:0];
      REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: alpha_words[idx - REG_WORD0] = data;
      default: ;
    endcase
  endtask

  // write sym_buf and a length, plus junk to the unused indexes
  task automatic load_alphabet(input int len);
    logic [WORD_W-1:0]    word;
    logic [REG_IDX_W-1:0] idx;
    int                   w, k, u;
    wait_quiet(4);
    for (w = 0; w < NUM_WORDS; w++) begin
      for (k = 0; k < SYMS_PER_WORD; k++)
        word[k * SYM_W +: SYM_W] = sym_buf[w * SYMS_PER_WORD + k];
      idx = REG_IDX_W'(REG_WORD0 + w);
      write_reg(idx, word);
    end
    // upper bits of the length write are junk and must be dropped
    word = {$urandom(), $urandom()};
    word[LEN_W-1:0] = LEN_W'(len);
    write_reg(REG_LEN, word);
    for (u = REG_WORD3 + 1; u < (1 << REG_IDX_W); u++) begin
      idx = REG_IDX_W'(u);
      write_reg(idx, {$urandom(), $urandom()});
    end
    wr_en <= 1'b0;
    alphabets_loaded++;
  endtask

  // leading symbols from a string, junk beyond it
  task automatic fill_alphabet(input string s);
    for (int i = 0; i < SYMBOL_SLOTS; i++)
      sym_buf[i] = (i < s.len()) ? s[i] : SYM_W'($urandom_range(0, 255));
  endtask

  // 32 distinct printable symbols in random order, no sign symbols
  task automatic shuffle_alphabet();
    logic [SYM_W-1:0] pool [$];
    logic [SYM_W-1:0] tmp;
    int               j;
    for (int c = int'(CH_LOW); c <= int'(CH_HIGH); c++)
      if (c != CH_PLUS && c != CH_MINUS) pool.push_back(SYM_W'(c));
    for (int i = pool.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int i = 0; i < SYMBOL_SLOTS; i++) sym_buf[i] = pool[i];
  endtask

  // values biased toward digit-count boundaries and range extremes
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    longint             p;
    int                 radix;
    radix = int'(alpha_len);
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1000);
      2: begin
        p = 1;
        if (radix >= 2)
          repeat ($urandom_range(1, 31))
            if (p * radix <= 64'h8000_0000) p = p * radix;
        v = VALUE_W'(p - $urandom_range(0, 1));
      end
      3: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                               : 32'h8000_0000 + $urandom_range(0, 3);
      4: begin
        v = 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(1)) v = ~v;
      end
      default: v = $urandom();
    endcase
    if (v != 32'h8000_0000 && $urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  // power-up alphabet has length zero and must be rejected
  task automatic test_reset_alphabet();
    send_value(32'd42);
    wait_quiet(4);
  endtask

  // decimal: zero, one, sign, carries into a new digit, the full range
  task automatic test_decimal_corners();
    logic [VALUE_W-1:0] vals [$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10,
             32'h7FFF_FFFF, 32'h8000_0000, 32'd1_000_000_000};
    fill_alphabet("0123456789");
    load_alphabet(10);
    foreach (vals[i]) begin
      send_value(vals[i]);
      wait_quiet(4);
    end
  endtask

  // smallest radix: the most negative value gives the longest text
  task automatic test_binary_extremes();
    logic [VALUE_W-1:0] vals [$];
    vals = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF};
    fill_alphabet("01");
    load_alphabet(2);
    foreach (vals[i]) begin
      send_value(vals[i]);
      wait_quiet(4);
    end
  endtask

  // largest radix with the lowest and highest printable symbols at the ends
  task automatic test_widest_alphabet();
    logic [VALUE_W-1:0] vals [$];
    vals = '{32'd0, 32'd31, 32'd32, 32'h8000_0000};
    fill_alphabet("!0123456789ABCDEFGHIJKLMNOPQRST~");
    load_alphabet(SYMBOL_SLOTS);
    foreach (vals[i]) begin
      send_value(vals[i]);
      wait_quiet(4);
    end
  endtask

  // each rule of alphabet validation on its own
  task automatic test_rejected_alphabets();
    fill_alphabet("0");
    load_alphabet(1);
    send_value(32'd5);
    fill_alphabet("0123456789ABCDEFGHIJKLMNOPQRSTUV");
    load_alphabet(SYMBOL_SLOTS + 1);
    send_value(32'd5);
    load_alphabet((1 << LEN_W) - 1);
    send_value(-32'sd5);
    fill_alphabet("01+3");
    load_alphabet(4);
    send_value(32'd7);
    fill_alphabet("01-3");
    load_alphabet(4);
    send_value(32'd7);
    fill_alphabet("01 3");
    load_alphabet(4);
    send_value(32'd7);
    fill_alphabet("0123");
    sym_buf[2] = SYM_W'(CH_HIGH + 1);
    load_alphabet(4);
    send_value(32'd7);
    fill_alphabet("0123456780");
    load_alphabet(10);
    send_value(32'd7);
    wait_quiet(4);
  endtask

  // random alphabets of many radices, values across the range, sender gaps
  task automatic test_random_formats();
    int lens [RANDOM_PHASES];
    int gaps [RANDOM_PHASES];
    lens = '{10, 2, SYMBOL_SLOTS, 16, 0, 0, 0, 0};
    gaps = '{0, 64, 21, 0, 64, 21, 64, 0};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      shuffle_alphabet();
      load_alphabet(lens[p] != 0 ? lens[p] : $urandom_range(2, SYMBOL_SLOTS));
      idle_pct = gaps[p];
      repeat (PHASE_VALUES) send_value(random_value());
    end
    idle_pct = 0;
  endtask

  // random spoiled alphabets, each tried with a few values
  task automatic test_random_faults();
    alphabet_fault_t fault;
    int              len, pos, pos2;
    for (int r = 0; r < FAULT_ROUNDS; r++) begin
      shuffle_alphabet();
      len  = $urandom_range(2, SYMBOL_SLOTS);
      pos  = $urandom_range(0, len - 1);
      fault = alphabet_fault_t'($urandom_range(BREAK_SHORT, BREAK_REPEAT));
      case (fault)
        BREAK_SHORT: len = $urandom_range(0, 1);
        BREAK_LONG:  len = $urandom_range(SYMBOL_SLOTS + 1, (1 << LEN_W) - 1);
        BREAK_SIGN:  sym_buf[pos] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
        BREAK_RANGE: sym_buf[pos] = $urandom_range(1) ? SYM_W'($urandom_range(0, CH_LOW - 1))
                                  : SYM_W'($urandom_range(CH_HIGH + 1, 255));
        BREAK_REPEAT: begin
          pos2 = (pos + $urandom_range(1, len - 1)) % len;
          sym_buf[pos2] = sym_buf[pos];
        end
        default: ;
      endcase
      load_alphabet(len);
      idle_pct = 21;
      repeat (FAULT_VALUES) send_value(random_value());
    end
    idle_pct = 0;
  endtask

  // main sequence
  initial begin
    alpha_len = '0;
    foreach (alpha_words[i]) alpha_words[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_reset_alphabet();
    test_decimal_corners();
    test_binary_extremes();
    test_widest_alphabet();
    test_rejected_alphabets();
    test_random_formats();
    test_random_faults();

    wait_quiet(SETTLE_CYCLES);
    $display("covered %0d values over %0d alphabets, %0d beats checked",
             values_sent, alphabets_loaded, beats_checked);
    $display("radix 2 to 32, rejected alphabets, 32-bit extremes, with and without gaps");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
